// File: hdl/x86alu_pkg.sv
package x86alu_pkg;

  // Operation codes carried on the mode field
  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_ADC = 4'd1,
    OP_SUB = 4'd2,
    OP_SBB = 4'd3,
    OP_AND = 4'd4,
    OP_OR  = 4'd5,
    OP_XOR = 4'd6,
    OP_SHL = 4'd7,
    OP_SAL = 4'd8,
    OP_SHR = 4'd9,
    OP_SAR = 4'd10,
    OP_MUL = 4'd11
  } alu_op_t;

  // Operand width codes; the unused code runs as 32 bits
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  localparam logic [31:0] MASK_8  = 32'h0000_00FF;
  localparam logic [31:0] MASK_16 = 32'h0000_FFFF;
  localparam logic [31:0] MASK_32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
    logic pf;
    logic cf;
  } flags_t;

endpackage

// File: hdl/x86_alu_with_flags.sv
// x86 integer ALU with kept EFLAGS bits (CF, PF, ZF, SF, OF).
//
// Input channel: in_valid / in_stall carry mode, width_code, src_operand and
// dest_operand. A beat is taken on a rising edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall carry result_value and
// the five flag outputs; the downstream side drives out_stall.
//
// A beat lands in the input register, then one pass through the ALU core
// (one 32x32 multiplier sets the critical path) writes the result register
// and the kept flags together. Throughput is one beat per cycle while
// out_stall is low; the next operation sees the flags of the previous one,
// so adc/sbb chains run back to back.
//
// Reset clears both valid bits and all kept flags. While out_stall holds a
// full result register, the input register keeps its beat and in_stall
// rises only once that register is also full; no beat is lost or repeated.
module x86_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  mode,
  input  logic [1:0]  width_code,
  input  logic [31:0] src_operand,
  input  logic [31:0] dest_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_value,
  output logic        carry_out,
  output logic        parity_out,
  output logic        zero_out,
  output logic        sign_out,
  output logic        overflow_out
);
  import x86alu_pkg::*;

  // Input register
  logic        s1_valid;
  logic [3:0]  s1_mode;
  logic [1:0]  s1_width;
  logic [31:0] s1_src;
  logic [31:0] s1_dest;

  // Kept flags, updated as each beat passes through the core
  flags_t      flags;
  flags_t      flags_next;
  logic [63:0] result_next;

  logic        advance;
  logic        load;

  // Move the staged beat on when the result register is empty or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the payload; hold it while the beat waits
  always_ff @(posedge clk) begin
    if (load) begin
      s1_mode  <= mode;
      s1_width <= width_code;
      s1_src   <= src_operand;
      s1_dest  <= dest_operand;
    end
  end

  x86alu_core u_core (
    .mode         (s1_mode),
    .width_code   (s1_width),
    .src_operand  (s1_src),
    .dest_operand (s1_dest),
    .flags        (flags),
    .result_value (result_next),
    .flags_next   (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (advance) begin
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register; drop nothing while out_stall holds it
  always_ff @(posedge clk) begin
    if (advance) begin
      result_value <= result_next;
      carry_out    <= flags_next.cf;
      parity_out   <= flags_next.pf;
      zero_out     <= flags_next.zf;
      sign_out     <= flags_next.sf;
      overflow_out <= flags_next.of;
    end
  end

  // The flags reported with a beat are the flags kept for the next one
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    advance |=> (carry_out == flags.cf) && (parity_out == flags.pf) &&
                (zero_out == flags.zf) && (sign_out == flags.sf) &&
                (overflow_out == flags.of))
    else $error("reported flags differ from kept flags");

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(flags))
    else $error("kept flags changed without a beat");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid && $stable(s1_dest) && $stable(s1_mode))
    else $error("staged beat lost while waiting");

  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_mode > OP_MUL)) |=> (result_value == 64'd0))
    else $error("unused mode gave a nonzero result");

endmodule

// File: hdl/x86alu_core.sv
module x86alu_core (
  input  logic [3:0]      mode,
  input  logic [1:0]      width_code,
  input  logic [31:0]     src_operand,
  input  logic [31:0]     dest_operand,
  input  x86alu_pkg::flags_t flags,
  output logic [63:0]     result_value,
  output x86alu_pkg::flags_t flags_next
);
  import x86alu_pkg::*;

  logic [31:0] mask;
  logic [31:0] sm;
  logic [31:0] dm;
  logic [4:0]  cnt;
  logic [4:0]  cnt_m1;
  logic [32:0] sum;
  logic [32:0] diff;
  logic [32:0] shl_t;
  logic [31:0] sar_ext;
  logic [63:0] prod;
  logic        cin;
  logic [31:0] res;
  logic        cf;
  logic        of;
  logic        top_bit;
  logic        mul_hi;

  always_comb begin
    case (width_code)
      WIDTH_8:  mask = MASK_8;
      WIDTH_16: mask = MASK_16;
      default:  mask = MASK_32;
    endcase
  end

  assign sm     = src_operand & mask;
  assign dm     = dest_operand & mask;
  assign cnt    = src_operand[4:0];
  assign cnt_m1 = cnt - 5'd1;
  assign cin    = flags.cf;

  assign sum  = {1'b0, dm} + {1'b0, sm} + {32'd0, (mode == OP_ADC) && cin};
  // Borrow shows as the top bit of the 33-bit difference
  assign diff = {1'b0, dm} - {1'b0, sm} - {32'd0, (mode == OP_SBB) && cin};
  assign shl_t = {1'b0, dm} << cnt;
  assign sar_ext = (dm & mask) | ((dm & ~(mask >> 1)) != 32'd0 ? ~mask : 32'd0);
  assign prod = dm * sm;

  always_comb begin
    case (width_code)
      WIDTH_8:  mul_hi = |prod[63:8];
      WIDTH_16: mul_hi = |prod[63:16];
      default:  mul_hi = |prod[63:32];
    endcase
  end

  // Pick the carry-out bit at position W of a 33-bit intermediate
  function automatic logic bit_at_w(input logic [1:0] wc, input logic [32:0] v);
    logic b;
    case (wc)
      WIDTH_8:  b = v[8];
      WIDTH_16: b = v[16];
      default:  b = v[32];
    endcase
    return b;
  endfunction

  // Pick the sign bit of a W-bit value
  function automatic logic bit_top(input logic [1:0] wc, input logic [31:0] v);
    logic b;
    case (wc)
      WIDTH_8:  b = v[7];
      WIDTH_16: b = v[15];
      default:  b = v[31];
    endcase
    return b;
  endfunction

  always_comb begin
    res          = 32'd0;
    cf           = 1'b0;
    of           = 1'b0;
    result_value = 64'd0;
    flags_next   = flags;
    top_bit      = 1'b0;
    unique case (mode)
      OP_ADD, OP_ADC: begin
        res = sum[31:0] & mask;
        cf  = bit_at_w(width_code, sum);
        of  = bit_top(width_code, ~(dm ^ sm) & (dm ^ res));
      end
      OP_SUB, OP_SBB: begin
        res = diff[31:0] & mask;
        cf  = diff[32];
        of  = bit_top(width_code, (dm ^ sm) & (dm ^ res));
      end
      OP_AND: res = dm & sm;
      OP_OR:  res = dm | sm;
      OP_XOR: res = dm ^ sm;
      OP_SHL, OP_SAL: begin
        res = shl_t[31:0] & mask;
        cf  = bit_at_w(width_code, shl_t);
        of  = cf ^ bit_top(width_code, res);
      end
      OP_SHR: begin
        res = dm >> cnt;
        cf  = dm[cnt_m1];
        of  = bit_top(width_code, dm);
      end
      OP_SAR: begin
        res = 32'($signed(sar_ext) >>> cnt) & mask;
        cf  = sar_ext[cnt_m1];
      end
      default: ;
    endcase

    top_bit = bit_top(width_code, res);

    unique case (mode)
      OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_AND, OP_OR, OP_XOR: begin
        result_value = {32'd0, res};
        flags_next   = '{of: of, sf: top_bit, zf: (res == 32'd0),
                         pf: ~^res[7:0], cf: cf};
      end
      OP_SHL, OP_SAL, OP_SHR, OP_SAR: begin
        if (cnt == 5'd0) begin
          // Zero count: pass the operand, hold every flag
          result_value = {32'd0, dm};
        end else begin
          result_value = {32'd0, res};
          flags_next   = '{of: of, sf: top_bit, zf: (res == 32'd0),
                           pf: ~^res[7:0], cf: cf};
        end
      end
      OP_MUL: begin
        result_value  = prod;
        flags_next.cf = mul_hi;
        flags_next.of = mul_hi;
      end
      default: result_value = 64'd0;
    endcase
  end

endmodule

// File: tb/x86_alu_checker.sv
module x86_alu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  mode,
  input  logic [1:0]  width_code,
  input  logic [31:0] src_operand,
  input  logic [31:0] dest_operand,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] result_value,
  input  logic        carry_out,
  input  logic        parity_out,
  input  logic        zero_out,
  input  logic        sign_out,
  input  logic        overflow_out,
  output int          mismatch_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import x86alu_pkg::*;

  typedef struct {
    logic [63:0] value;
    flags_t      flags;
  } alu_result_t;

  alu_result_t pending_q[$];
  flags_t      eflags_model;
  int          fail_total = 0;
  int          waiting_cnt = 0;

  assign mismatch_count = fail_total;
  assign outstanding    = waiting_cnt;

  // One x86 ALU operation against the kept flags.
  function automatic alu_result_t exec_alu(logic [3:0] op, logic [1:0] wc,
                                           logic [31:0] src, logic [31:0] dst,
                                           flags_t prev);
    int unsigned w;
    int unsigned top;
    logic [63:0] mask, sm, dm, t, res, ext, ovf_vec;
    logic [4:0]  cnt;
    logic        cin, brw, cf, of, update_all;
    alu_result_t r;

    case (wc)
      WIDTH_8:  w = 8;
      WIDTH_16: w = 16;
      default:  w = 32;
    endcase
    mask       = (64'd1 << w) - 64'd1;
    sm         = {32'd0, src} & mask;
    dm         = {32'd0, dst} & mask;
    top        = w - 1;
    cnt        = src[4:0];
    cin        = prev.cf;
    res        = '0;
    cf         = 1'b0;
    of         = 1'b0;
    update_all = 1'b0;
    r.flags    = prev;

    case (op)
      OP_ADD, OP_ADC: begin
        t          = dm + sm + ((op == OP_ADC) ? {63'd0, cin} : 64'd0);
        res        = t & mask;
        cf         = t[w];
        ovf_vec    = ~(dm ^ sm) & (dm ^ res);
        of         = ovf_vec[top];
        update_all = 1'b1;
      end
      OP_SUB, OP_SBB: begin
        brw        = (op == OP_SBB) & cin;
        t          = (dm - sm - {63'd0, brw}) & 64'h1_FFFF_FFFF;
        res        = t & mask;
        cf         = (sm + {63'd0, brw}) > dm;
        ovf_vec    = (dm ^ sm) & (dm ^ res);
        of         = ovf_vec[top];
        update_all = 1'b1;
      end
      OP_AND, OP_OR, OP_XOR: begin
        res        = (op == OP_AND) ? (dm & sm) : (op == OP_OR) ? (dm | sm) : (dm ^ sm);
        update_all = 1'b1;
      end
      OP_SHL, OP_SAL: begin
        if (cnt == 5'd0) begin
          res = dm;
        end else begin
          t          = dm << cnt;
          res        = t & mask;
          cf         = t[w];
          of         = cf ^ res[top];
          update_all = 1'b1;
        end
      end
      OP_SHR: begin
        if (cnt == 5'd0) begin
          res = dm;
        end else begin
          res        = dm >> cnt;
          cf         = dm[cnt - 5'd1];
          of         = dm[top];
          update_all = 1'b1;
        end
      end
      OP_SAR: begin
        if (cnt == 5'd0) begin
          res = dm;
        end else begin
          ext        = dm[top] ? (dm | ~mask) : dm;
          cf         = ext[cnt - 5'd1];
          res        = (ext >> cnt) & mask;
          update_all = 1'b1;
        end
      end
      OP_MUL: begin
        // only CF and OF move; they flag a nonzero upper half
        res        = dm * sm;
        r.flags.cf = |(res >> w);
        r.flags.of = |(res >> w);
      end
      default: res = '0;
    endcase

    if (update_all) begin
      r.flags.cf = cf;
      r.flags.pf = ~^res[7:0];
      r.flags.zf = (res == 64'd0);
      r.flags.sf = res[top];
      r.flags.of = of;
    end
    r.value = res;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_total++;
      $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    alu_result_t nxt;
    alu_result_t want;
    if (rst) begin
      pending_q.delete();
      eflags_model = '0;
      waiting_cnt <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt = exec_alu(mode, width_code, src_operand, dest_operand, eflags_model);
        eflags_model = nxt.flags;
        pending_q.push_back(nxt);
      end
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          fail_total++;
          $error("result beat with no prediction waiting: value %0h", result_value);
        end else begin
          want = pending_q.pop_front();
          check_field("result_value", want.value, result_value);
          check_field("carry_out", {63'd0, want.flags.cf}, {63'd0, carry_out});
          check_field("parity_out", {63'd0, want.flags.pf}, {63'd0, parity_out});
          check_field("zero_out", {63'd0, want.flags.zf}, {63'd0, zero_out});
          check_field("sign_out", {63'd0, want.flags.sf}, {63'd0, sign_out});
          check_field("overflow_out", {63'd0, want.flags.of}, {63'd0, overflow_out});
        end
      end
      waiting_cnt <= pending_q.size();
    end
  end

endmodule

// File: tb/tb_x86_alu_with_flags.sv
module tb_x86_alu_with_flags;
  timeunit 1ns;
  timeprecision 1ps;
  import x86alu_pkg::*;

  localparam int         RESET_CYCLES      = 6;
  localparam int         RANDOM_ITEMS      = 700;
  localparam int         BURST_SPAN        = 80;
  localparam int         PAUSE_AT_ITEM     = 450;
  localparam int         LONG_HOLD_AT_ITEM = 300;
  localparam int         LONG_HOLD_CYCLES  = 250;
  localparam int         DRAIN_CYCLES      = 20;
  localparam int         CYCLE_LIMIT       = 400000;
  // mode codes past mul and the spare width code that runs as 32 bits
  localparam logic [3:0] FIRST_UNUSED_MODE = 4'd12;
  localparam logic [3:0] LAST_MODE         = 4'd15;
  localparam logic [1:0] WIDTH_32_ALIAS    = 2'd3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  mode;
  logic [1:0]  width_code;
  logic [31:0] src_operand;
  logic [31:0] dest_operand;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] result_value;
  logic        carry_out;
  logic        parity_out;
  logic        zero_out;
  logic        sign_out;
  logic        overflow_out;

  int mismatch_count;
  int results_waiting;
  int items_sent = 0;
  int cycle_cnt = 0;
  bit long_hold_done = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  x86_alu_with_flags u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .width_code   (width_code),
    .src_operand  (src_operand),
    .dest_operand (dest_operand),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .carry_out    (carry_out),
    .parity_out   (parity_out),
    .zero_out     (zero_out),
    .sign_out     (sign_out),
    .overflow_out (overflow_out)
  );

  // The checker sees both channels as a bystander and keeps its own flag copy.
  x86_alu_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .width_code     (width_code),
    .src_operand    (src_operand),
    .dest_operand   (dest_operand),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_value   (result_value),
    .carry_out      (carry_out),
    .parity_out     (parity_out),
    .zero_out       (zero_out),
    .sign_out       (sign_out),
    .overflow_out   (overflow_out),
    .mismatch_count (mismatch_count),
    .outstanding    (results_waiting)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly back to back, sometimes a short gap, now and then a long gap.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Operands lean on the corners: zero, all ones, single bits, small values
  // and the signed boundaries of each width.
  function automatic logic [31:0] pick_operand();
    int          sel;
    int unsigned sign_bit;
    sel = $urandom_range(0, 9);
    case ($urandom_range(0, 2))
      0:       sign_bit = 7;
      1:       sign_bit = 15;
      default: sign_bit = 31;
    endcase
    case (sel)
      0:       return '0;
      1:       return MASK_32;
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return $urandom_range(0, 15);
      4:       return 32'd1 << sign_bit;
      5:       return (32'd1 << sign_bit) - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one beat after an optional idle gap and hold it until taken.
  // Leave valid high on return so the next beat can follow with no bubble.
  task automatic send_op(logic [3:0] op, logic [1:0] wc, logic [31:0] s,
                         logic [31:0] d, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= op;
    width_code   <= wc;
    src_operand  <= s;
    dest_operand <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_waiting != 0);
  endtask

  // Receiver: short ready runs broken by stalls, some long ready stretches,
  // and one long hold-off once the stream is well under way so the block
  // fills up and pushes back on its input.
  initial begin : rx_drive
    int ready_len;
    int hold_len;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!long_hold_done && items_sent >= LONG_HOLD_AT_ITEM) begin
        long_hold_done = 1'b1;
        hold_len = LONG_HOLD_CYCLES;
      end else begin
        hold_len = pick_gap();
      end
      ready_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 4);
      out_stall <= 1'b0;
      repeat (ready_len) @(posedge clk);
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [3:0]  op;
    logic [1:0]  wc;
    logic [31:0] s;
    logic [31:0] d;
    bit          burst;

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    mode         <= OP_ADD;
    width_code   <= WIDTH_8;
    src_operand  <= '0;
    dest_operand <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners, back to back so adc/sbb see the carry just made.
    send_op(OP_ADD, WIDTH_8,  32'h0000_0001, 32'h0000_00FF, 0); // wrap to zero, CF
    send_op(OP_ADC, WIDTH_8,  32'h0000_0000, 32'h0000_007F, 0); // carry in tips OF
    send_op(OP_ADD, WIDTH_32, MASK_32,       MASK_32,       0);
    send_op(OP_ADC, WIDTH_16, MASK_16,       MASK_16,       0);
    send_op(OP_SUB, WIDTH_16, 32'h0000_0001, 32'h0000_0000, 0); // borrow
    send_op(OP_SBB, WIDTH_32, 32'h0000_0000, 32'h8000_0000, 0); // borrow in, OF
    send_op(OP_SBB, WIDTH_8,  32'h0000_0055, 32'h0000_0055, 0);
    send_op(OP_AND, WIDTH_32, MASK_32,       MASK_32,       0);
    send_op(OP_OR,  WIDTH_8,  32'h0000_0000, 32'h0000_0000, 0);
    send_op(OP_XOR, WIDTH_16, 32'h0000_A5A5, 32'h0000_5A5A, 0);
    send_op(OP_SHL, WIDTH_8,  32'h0000_0001, 32'h0000_0080, 0); // bit out to CF
    send_op(OP_SAL, WIDTH_16, 32'h0000_0020, 32'h0000_1234, 0); // count masks to zero
    send_op(OP_SHL, WIDTH_8,  32'h0000_000C, 32'h0000_00FF, 0); // count past width
    send_op(OP_SHR, WIDTH_32, 32'h0000_001F, MASK_32,       0);
    send_op(OP_SHR, WIDTH_16, 32'h0000_0011, 32'h0000_8001, 0); // count past width
    send_op(OP_SAR, WIDTH_8,  32'h0000_0009, 32'h0000_0080, 0); // fills with sign
    send_op(OP_SAR, WIDTH_32, 32'hFFFF_FFE1, 32'h8000_0001, 0); // upper count bits dropped
    send_op(OP_SAR, WIDTH_16, 32'h0000_0000, 32'h0000_8000, 0); // zero count keeps flags
    send_op(OP_MUL, WIDTH_32, MASK_32,       MASK_32,       0); // full 64-bit product
    send_op(OP_MUL, WIDTH_8,  32'h0000_000F, 32'h0000_000F, 0); // fits, CF/OF clear
    send_op(OP_MUL, WIDTH_16, 32'h0000_0100, 32'h0000_0100, 0);
    send_op(OP_ADD, WIDTH_32_ALIAS, 32'h0000_0001, 32'h7FFF_FFFF, 0);
    send_op(FIRST_UNUSED_MODE, WIDTH_8, MASK_32, MASK_32, 0);
    send_op(LAST_MODE, WIDTH_32, 32'h1234_5678, 32'h9ABC_DEF0, 0);
    send_op(OP_ADD, WIDTH_8,  32'hDEAD_BE01, 32'hCAFE_F0FF, 0); // upper bits masked
    drain_results();

    // Random stream: alternate bursts with no gaps and gappy stretches.
    for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if (idx == PAUSE_AT_ITEM)
        drain_results();
      op = ($urandom_range(0, 49) == 0) ?
           4'($urandom_range(FIRST_UNUSED_MODE, LAST_MODE)) :
           4'($urandom_range(OP_ADD, OP_MUL));
      wc = ($urandom_range(0, 19) == 0) ? WIDTH_32_ALIAS :
           2'($urandom_range(WIDTH_8, WIDTH_32));
      d  = pick_operand();
      if (op >= OP_SHL && op <= OP_SAR)
        s = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 31);
      else
        s = pick_operand();
      burst = ((idx / BURST_SPAN) % 2) == 0;
      send_op(op, wc, s, d, burst ? 0 : pick_gap());
    end

    // Wait out the tail, then idle for DRAIN_CYCLES more to catch stray beats.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
